// ----- design/jsesc_pkg.sv -----
// ============================================================================
// jsesc_pkg
// Shared types, character codes and helpers of the JSON string escaper.
// ============================================================================
package jsesc_pkg;

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_FF    = 8'h0C;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_TAB   = 8'h09;

	// Replacement character and surrogate prefixes
	localparam logic [15:0] U_REPL    = 16'hFFFD;
	localparam logic [5:0]  SURR_HI   = 6'b110110;
	localparam logic [5:0]  SURR_LO   = 6'b110111;

	// Escape group that a byte produces between the quotes
	typedef enum logic [2:0] {
		K_NONE,
		K_CHAR,
		K_ESC,
		K_U1,
		K_U2
	} kind_t;

	// Word passed from front to back: everything one item emits
	typedef struct packed {
		logic        open;
		logic        close;
		kind_t       kind;
		logic [7:0]  chr;
		logic [15:0] u_hi;
		logic [15:0] u_lo;
	} cmd_t;

	// Serializer position
	typedef enum logic [1:0] {
		PH_OPEN,
		PH_MID,
		PH_CLOSE
	} phase_t;

	// Lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

	// Number of characters in an escape group
	function automatic logic [3:0] kind_len(input kind_t k);
		logic [3:0] n;
		unique case (k)
			K_CHAR:  n = 4'd1;
			K_ESC:   n = 4'd2;
			K_U1:    n = 4'd6;
			K_U2:    n = 4'd12;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/jsesc_front.sv -----
// ============================================================================
// jsesc_front
// Accepts input bytes, tracks UTF-8 sequences and classifies each item into
// one queue word describing the characters it emits.
// ============================================================================
module jsesc_front import jsesc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] byte_in,
	input  logic       has_byte,
	input  logic       is_first,
	input  logic       is_last,
	output logic       push,
	output cmd_t       cmd
);

	logic [1:0]  bp_q, sl_q;
	logic [20:0] acc_q;
	logic        ok_q;

	logic [1:0]  bp_d, sl_d;
	logic [20:0] acc_d;
	logic        ok_d;
	logic [20:0] seq_off;
	logic        seq_valid;
	logic [7:0]  esc_chr;

	// Decode one item against the sequence state
	always_comb begin
		bp_d      = bp_q;
		sl_d      = sl_q;
		acc_d     = acc_q;
		ok_d      = ok_q;
		cmd       = '0;
		cmd.kind  = K_NONE;
		seq_off   = '0;
		seq_valid = 1'b0;
		esc_chr   = '0;

		if (is_first) begin
			bp_d    = '0;
			sl_d    = '0;
			acc_d   = '0;
			ok_d    = 1'b1;
			cmd.open = 1'b1;
		end

		if (has_byte) begin
			if (bp_d != 2'd0) begin
				// Collect a follower, whatever its value
				if (byte_in[7:6] != 2'b10) begin
					ok_d = 1'b0;
				end
				acc_d = {acc_d[14:0], byte_in[5:0]};
				bp_d  = bp_d - 2'd1;
				if (bp_d == 2'd0) begin
					unique case (sl_d)
						2'd1: seq_valid = acc_d >= 21'h80;
						2'd2: seq_valid = acc_d >= 21'h800 &&
							(acc_d < 21'hD800 || acc_d > 21'hDFFF);
						2'd3: seq_valid = acc_d >= 21'h10000 && acc_d <= 21'h10FFFF;
						default: seq_valid = 1'b0;
					endcase
					seq_valid = seq_valid & ok_d;
					seq_off   = acc_d - 21'h10000;
					if (!seq_valid) begin
						cmd.kind = K_U1;
						cmd.u_hi = U_REPL;
					end else if (acc_d[20:16] != 5'd0) begin
						cmd.kind = K_U2;
						cmd.u_hi = {SURR_HI, seq_off[19:10]};
						cmd.u_lo = {SURR_LO, seq_off[9:0]};
					end else begin
						cmd.kind = K_U1;
						cmd.u_hi = acc_d[15:0];
					end
					sl_d  = '0;
					acc_d = '0;
					ok_d  = 1'b1;
				end
			end else if (!byte_in[7]) begin
				// ASCII: short escape, control escape or pass through
				case (byte_in)
					CH_QUOTE:  esc_chr = CH_QUOTE;
					CH_BSLASH: esc_chr = CH_BSLASH;
					CH_SLASH:  esc_chr = CH_SLASH;
					CTL_BS:    esc_chr = CH_LOW_B;
					CTL_FF:    esc_chr = CH_LOW_F;
					CTL_LF:    esc_chr = CH_LOW_N;
					CTL_CR:    esc_chr = CH_LOW_R;
					CTL_TAB:   esc_chr = CH_LOW_T;
					default:   esc_chr = '0;
				endcase
				if (esc_chr != 8'd0) begin
					cmd.kind = K_ESC;
					cmd.chr  = esc_chr;
				end else if (byte_in[6:5] == 2'b00) begin
					cmd.kind = K_U1;
					cmd.u_hi = {8'd0, byte_in};
				end else begin
					cmd.kind = K_CHAR;
					cmd.chr  = byte_in;
				end
			end else if (byte_in[7:5] == 3'b110) begin
				// Lead bytes open a sequence
				acc_d = {16'd0, byte_in[4:0]};
				sl_d  = 2'd1;
				bp_d  = 2'd1;
				ok_d  = 1'b1;
			end else if (byte_in[7:4] == 4'b1110) begin
				acc_d = {17'd0, byte_in[3:0]};
				sl_d  = 2'd2;
				bp_d  = 2'd2;
				ok_d  = 1'b1;
			end else if (byte_in[7:3] == 5'b11110) begin
				acc_d = {18'd0, byte_in[2:0]};
				sl_d  = 2'd3;
				bp_d  = 2'd3;
				ok_d  = 1'b1;
			end else begin
				cmd.kind = K_U1;
				cmd.u_hi = U_REPL;
			end
		end

		if (is_last) begin
			// Flush a sequence cut short, then close
			if (bp_d != 2'd0) begin
				cmd.kind = K_U1;
				cmd.u_hi = U_REPL;
			end
			bp_d      = '0;
			sl_d      = '0;
			acc_d     = '0;
			ok_d      = 1'b1;
			cmd.close = 1'b1;
		end
	end

	// Drop items that emit nothing
	assign push = accept && (cmd.open || cmd.close || cmd.kind != K_NONE);

	// Advance sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q  <= '0;
			sl_q  <= '0;
			acc_q <= '0;
			ok_q  <= 1'b1;
		end else if (accept) begin
			bp_q  <= bp_d;
			sl_q  <= sl_d;
			acc_q <= acc_d;
			ok_q  <= ok_d;
		end
	end

endmodule

// ----- design/jsesc_queue.sv -----
// ============================================================================
// jsesc_queue
// Small register queue of command words between front and back.
// ============================================================================
module jsesc_queue import jsesc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	input  logic pop,
	output cmd_t cmd_out,
	output logic empty,
	output logic full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = count_q == CNT_W'(0);
	assign full    = count_q == CNT_W'(DEPTH);
	assign cmd_out = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ----- design/jsesc_back.sv -----
// ============================================================================
// jsesc_back
// Walks the head command word character by character into an output
// register and pops the word after its last character.
// ============================================================================
module jsesc_back import jsesc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       string_end
);

	phase_t     phase_q, phase_d, eff_phase;
	logic [3:0] sub_q, sub_d;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_end_q, string_end_q;

	logic       load;
	logic [3:0] mid_len;
	logic       mid_last;
	logic       is_last_chr;
	logic [7:0] chr;
	logic       sel_lo;
	logic [2:0] s6;
	logic [15:0] uval;
	logic [7:0] mid_chr;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign pop  = load && is_last_chr;

	// Pick the character at the current position of the head word
	always_comb begin
		mid_len  = kind_len(cmd.kind);
		mid_last = sub_q == mid_len - 4'd1;
		sel_lo   = sub_q >= 4'd6;
		s6       = sel_lo ? 3'(sub_q - 4'd6) : sub_q[2:0];
		uval     = sel_lo ? cmd.u_lo : cmd.u_hi;

		case (s6)
			3'd0:    mid_chr = CH_BSLASH;
			3'd1:    mid_chr = CH_LOW_U;
			3'd2:    mid_chr = hex_char(uval[15:12]);
			3'd3:    mid_chr = hex_char(uval[11:8]);
			3'd4:    mid_chr = hex_char(uval[7:4]);
			default: mid_chr = hex_char(uval[3:0]);
		endcase
		if (cmd.kind == K_CHAR) begin
			mid_chr = cmd.chr;
		end else if (cmd.kind == K_ESC) begin
			mid_chr = (sub_q == 4'd0) ? CH_BSLASH : cmd.chr;
		end
	end

	// Skip absent groups, then choose character and next position
	always_comb begin
		eff_phase = phase_q;
		if (eff_phase == PH_OPEN && !cmd.open) begin
			eff_phase = PH_MID;
		end
		if (eff_phase == PH_MID && cmd.kind == K_NONE) begin
			eff_phase = PH_CLOSE;
		end

		phase_d = phase_q;
		sub_d   = sub_q;
		unique case (eff_phase)
			PH_OPEN: begin
				chr         = CH_QUOTE;
				is_last_chr = cmd.kind == K_NONE && !cmd.close;
			end
			PH_MID: begin
				chr         = mid_chr;
				is_last_chr = mid_last && !cmd.close;
			end
			default: begin
				chr         = CH_QUOTE;
				is_last_chr = 1'b1;
			end
		endcase

		if (load) begin
			if (is_last_chr) begin
				phase_d = PH_OPEN;
				sub_d   = '0;
			end else if (eff_phase == PH_OPEN) begin
				phase_d = PH_MID;
				sub_d   = '0;
			end else if (eff_phase == PH_MID && mid_last) begin
				phase_d = PH_CLOSE;
			end else begin
				sub_d = sub_q + 4'd1;
			end
		end
	end

	// Hold serializer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			sub_q   <= '0;
		end else begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q   <= chr;
			run_end_q    <= is_last_chr;
			string_end_q <= eff_phase == PH_CLOSE;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

`ifndef SYNTHESIS
	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && string_end_q |-> run_end_q)
		else $error("closing quote not last of its run");
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q < 4'd12)
		else $error("serializer position out of range");
`endif

endmodule

// ----- design/json_string_escaper_utf8_unit.sv -----
// ============================================================================
// json_string_escaper_utf8_unit
// JSON string escaper with UTF-8 validation: bytes in, literal characters out.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) takes one word per cycle while in_stall
//   is low: byte_in with has_byte, is_first and is_last marks. Output channel
//   (out_valid / out_stall) gives one character of the quoted JSON literal per
//   output word, with run_end on the last character of an input word and
//   string_end on the closing quote.
//   The first character of a word is registered in the queue and then in the
//   output register. A word yields 0 to 13 characters; the back end emits one
//   character per cycle while out_stall is low, so sustained input rate is
//   bounded by the single-character output serializer.
//   Input is taken every cycle while the front/back queue (QUEUE_DEPTH words)
//   has room; words that yield no characters never occupy it.
//   Reset clears the UTF-8 sequence state, empties the queue and drops any
//   pending output. When the receiver stalls, the output word holds, the
//   queue fills, and then in_stall rises.
// ============================================================================
module json_string_escaper_utf8_unit import jsesc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       has_byte,
	input  logic       is_first,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       string_end
);

	logic accept;
	logic push, pop, q_empty, q_full;
	cmd_t front_cmd, head_cmd;

	// Stall input while the queue is full
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	jsesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_in  (byte_in),
		.has_byte (has_byte),
		.is_first (is_first),
		.is_last  (is_last),
		.push     (push),
		.cmd      (front_cmd)
	);

	jsesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (front_cmd),
		.pop     (pop),
		.cmd_out (head_cmd),
		.empty   (q_empty),
		.full    (q_full)
	);

	jsesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.empty      (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
